[rtl/rotation_matrix_to_quaternion_defines.svh]
// Assertion macros used by the port-level checker file.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RMQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled in reset
`define RMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/rmq_pkg.sv]
// Types and constants of the rotation matrix to quaternion pipeline.
`default_nettype none
package rmq_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC       = DATA_WIDTH - 2;
    localparam int VW         = DATA_WIDTH + 3;     // signed branch vector
    localparam int MW         = DATA_WIDTH + 2;     // raw magnitude
    localparam int MAG_W      = 31;                 // normalized magnitude
    localparam int SHW        = 6;
    localparam int SUMSQ_W    = 64;
    localparam int NORM_W     = 32;
    localparam int DIV_W      = MAG_W + FRAC + 1;
    localparam int Q_W        = FRAC + 1;
    localparam logic signed [DATA_WIDTH-1:0] ONE =
        {{(DATA_WIDTH-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] r00;
        logic signed [DATA_WIDTH-1:0] r01;
        logic signed [DATA_WIDTH-1:0] r02;
        logic signed [DATA_WIDTH-1:0] r10;
        logic signed [DATA_WIDTH-1:0] r11;
        logic signed [DATA_WIDTH-1:0] r12;
        logic signed [DATA_WIDTH-1:0] r20;
        logic signed [DATA_WIDTH-1:0] r21;
        logic signed [DATA_WIDTH-1:0] r22;
    } t_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] qw;
        logic signed [DATA_WIDTH-1:0] qx;
        logic signed [DATA_WIDTH-1:0] qy;
        logic signed [DATA_WIDTH-1:0] qz;
        logic                         degenerate;
    } t_out;

    typedef struct packed {
        logic [3:0][MAG_W-1:0] mag;
        logic [3:0]            neg;
        logic                  deg;
    } t_item;

endpackage
`default_nettype wire

[rtl/rmq_front.sv]
// Branch select, magnitude normalization and sum of squares (four stages).
`default_nettype none
module rmq_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  rmq_pkg::t_in                 i_data,
    output logic                         o_valid,
    output rmq_pkg::t_item               o_item,
    output logic [rmq_pkg::SUMSQ_W-1:0]  o_sumsq
);
    import rmq_pkg::*;

    localparam int TOP = MAG_W - 1;
    localparam int EXT_W = MW + MAG_W;
    localparam logic signed [VW-1:0] ONE_V = {{(VW-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};

    logic signed [VW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, tr, rad;
    logic signed [VW-1:0] v [4];
    logic [3:0][MW-1:0]   n1_mag;
    logic [3:0]           n1_neg;
    logic [3:0][MW-1:0]   r1_mag;
    logic [3:0]           r1_neg;
    logic                 r1_valid;

    logic [MW-1:0]        orv;
    logic [SHW-1:0]       pos, sh;
    logic                 up;
    logic [EXT_W-1:0]     ext;
    t_item                n2_item, r2_item, r3_item, r4_item;
    logic                 r2_valid, r3_valid, r4_valid;
    logic [3:0][2*MAG_W-1:0] r3_sq;
    logic [SUMSQ_W-1:0]   r4_sumsq;

    // stage 1: branch vector, sign and magnitude
    always_comb begin
        e00 = VW'(i_data.r00); e01 = VW'(i_data.r01); e02 = VW'(i_data.r02);
        e10 = VW'(i_data.r10); e11 = VW'(i_data.r11); e12 = VW'(i_data.r12);
        e20 = VW'(i_data.r20); e21 = VW'(i_data.r21); e22 = VW'(i_data.r22);
        tr  = e00 + e11 + e22;
        rad = '0;
        if (tr > 0) begin
            v[0] = ONE_V + tr;
            v[1] = e21 - e12;
            v[2] = e02 - e20;
            v[3] = e10 - e01;
        end else if (e00 > e11 && e00 > e22) begin
            rad  = ONE_V + e00 - e11 - e22;
            v[0] = e21 - e12;
            v[1] = rad[VW-1] ? '0 : rad;
            v[2] = e01 + e10;
            v[3] = e02 + e20;
        end else if (e11 > e22) begin
            rad  = ONE_V + e11 - e00 - e22;
            v[0] = e02 - e20;
            v[1] = e01 + e10;
            v[2] = rad[VW-1] ? '0 : rad;
            v[3] = e12 + e21;
        end else begin
            rad  = ONE_V + e22 - e00 - e11;
            v[0] = e10 - e01;
            v[1] = e02 + e20;
            v[2] = e12 + e21;
            v[3] = rad[VW-1] ? '0 : rad;
        end
        for (int i = 0; i < 4; i++) begin
            n1_neg[i] = v[i][VW-1];
            n1_mag[i] = n1_neg[i] ? MW'(-v[i]) : MW'(v[i]);
        end
    end

    // stage 2: common shift so the largest magnitude has its top bit at TOP
    always_comb begin
        orv = r1_mag[0] | r1_mag[1] | r1_mag[2] | r1_mag[3];
        pos = '0;
        for (int i = 0; i < MW; i++) begin
            if (orv[i]) begin
                pos = SHW'(i);
            end
        end
        up = pos < SHW'(TOP);
        sh = up ? (SHW'(TOP) - pos) : (pos - SHW'(TOP));
        n2_item.neg = r1_neg;
        n2_item.deg = (orv == '0);
        for (int i = 0; i < 4; i++) begin
            ext = EXT_W'(r1_mag[i]);
            n2_item.mag[i] = up ? MAG_W'(ext << sh) : MAG_W'(ext >> sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag   <= n1_mag;
            r1_neg   <= n1_neg;
            r2_item  <= n2_item;
            r3_item  <= r2_item;
            for (int i = 0; i < 4; i++) begin
                r3_sq[i] <= r2_item.mag[i] * r2_item.mag[i];
            end
            r4_item  <= r3_item;
            r4_sumsq <= SUMSQ_W'(r3_sq[0]) + SUMSQ_W'(r3_sq[1])
                      + SUMSQ_W'(r3_sq[2]) + SUMSQ_W'(r3_sq[3]);
        end
    end

    assign o_valid = r4_valid;
    assign o_item  = r4_item;
    assign o_sumsq = r4_sumsq;

endmodule
`default_nettype wire

[rtl/rmq_sqrt.sv]
// Integer square root of the sum of squares, one result bit per stage.
`default_nettype none
module rmq_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  rmq_pkg::t_item               i_item,
    input  logic [rmq_pkg::SUMSQ_W-1:0]  i_sumsq,
    output logic                         o_valid,
    output rmq_pkg::t_item               o_item,
    output logic [rmq_pkg::NORM_W-1:0]   o_norm
);
    import rmq_pkg::*;

    localparam int NS = SUMSQ_W / 2;

    logic [SUMSQ_W-1:0] r_n   [NS];
    logic [SUMSQ_W-1:0] r_r   [NS];
    logic               r_vld [NS];
    t_item              r_item[NS];

    genvar j;
    for (j = 0; j < NS; j++) begin : g_stage
        localparam logic [SUMSQ_W-1:0] BIT = SUMSQ_W'(1) << (SUMSQ_W - 2 - 2 * j);
        logic [SUMSQ_W-1:0] s_n, s_r, s_t;
        logic               s_v;
        t_item              s_item;

        if (j == 0) begin : g_head
            assign s_n    = i_sumsq;
            assign s_r    = '0;
            assign s_v    = i_valid;
            assign s_item = i_item;
        end else begin : g_body
            assign s_n    = r_n[j-1];
            assign s_r    = r_r[j-1];
            assign s_v    = r_vld[j-1];
            assign s_item = r_item[j-1];
        end

        assign s_t = s_r + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_item[j] <= s_item;
                if (s_n >= s_t) begin
                    r_n[j] <= s_n - s_t;
                    r_r[j] <= (s_r >> 1) + BIT;
                end else begin
                    r_n[j] <= s_n;
                    r_r[j] <= s_r >> 1;
                end
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_item  = r_item[NS-1];
    assign o_norm  = NORM_W'(r_r[NS-1]);

endmodule
`default_nettype wire

[rtl/rmq_div.sv]
// Rounded division of the four magnitudes by the norm, one quotient bit per stage.
`default_nettype none
module rmq_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  rmq_pkg::t_item              i_item,
    input  logic [rmq_pkg::NORM_W-1:0]  i_norm,
    output logic                        o_valid,
    output rmq_pkg::t_out               o_data
);
    import rmq_pkg::*;

    localparam int ND = Q_W;

    typedef struct packed {
        logic [3:0][DIV_W-1:0] rem;
        logic [3:0][Q_W-1:0]   q;
        logic [NORM_W-1:0]     norm;
        logic [3:0]            neg;
        logic                  deg;
    } t_div_st;

    t_div_st r_st  [ND+1];
    logic    r_vld [ND+1];
    t_div_st n_st0;

    logic [3:0][DATA_WIDTH-1:0] qv, res;

    // prep: dividend = mag * ONE + norm / 2
    always_comb begin
        n_st0.norm = i_norm;
        n_st0.neg  = i_item.neg;
        n_st0.deg  = i_item.deg;
        n_st0.q    = '0;
        for (int i = 0; i < 4; i++) begin
            n_st0.rem[i] = (DIV_W'(i_item.mag[i]) << FRAC) + DIV_W'(i_norm >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_st0;
        end
    end

    genvar j;
    for (j = 0; j < ND; j++) begin : g_stage
        localparam int K = FRAC - j;
        logic [DIV_W-1:0] s_d;
        t_div_st          s_nx;

        assign s_d = DIV_W'(r_st[j].norm) << K;

        always_comb begin
            s_nx = r_st[j];
            for (int i = 0; i < 4; i++) begin
                if (r_st[j].rem[i] >= s_d) begin
                    s_nx.rem[i]  = r_st[j].rem[i] - s_d;
                    s_nx.q[i][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[j+1] <= r_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[j+1] <= s_nx;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            qv[i]  = DATA_WIDTH'(r_st[ND].q[i]);
            res[i] = r_st[ND].deg ? '0 : (r_st[ND].neg[i] ? (-qv[i]) : qv[i]);
        end
        o_data.qw         = res[0];
        o_data.qx         = res[1];
        o_data.qy         = res[2];
        o_data.qz         = res[3];
        o_data.degenerate = r_st[ND].deg;
    end

    assign o_valid = r_vld[ND];

endmodule
`default_nettype wire

[rtl/rotation_matrix_to_quaternion.sv]
// Top level: rotation matrix to unit quaternion pipeline.
//
//   channel | valid        | stall        | payload
//   in      | i_in_valid   | o_in_stall   | i_in_data  (rmq_pkg::t_in)
//   out     | o_out_valid  | i_out_stall  | o_out_data (rmq_pkg::t_out)
//
// One matrix per cycle while the output is not stalled; the pipeline holds 4 front, 32 square root,
// 16 divide and 1 output register stages. The square root and divider stages set the depth.
// Reset clears only the valid bits.
// A stalled output beat freezes the whole pipeline; the input stalls then too.
`default_nettype none
module rotation_matrix_to_quaternion (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rmq_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rmq_pkg::t_out  o_out_data
);
    import rmq_pkg::*;

    logic                 en;
    logic                 f_valid, s_valid, d_valid;
    t_item                f_item, s_item;
    logic [SUMSQ_W-1:0]   f_sumsq;
    logic [NORM_W-1:0]    s_norm;
    t_out                 d_data;
    logic                 r_out_valid;
    t_out                 r_out;

    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (f_valid),
        .o_item  (f_item),
        .o_sumsq (f_sumsq)
    );

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_item  (f_item),
        .i_sumsq (f_sumsq),
        .o_valid (s_valid),
        .o_item  (s_item),
        .o_norm  (s_norm)
    );

    rmq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_item  (s_item),
        .i_norm  (s_norm),
        .o_valid (d_valid),
        .o_data  (d_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= d_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

[rtl/rmq_checker.sv]
// Port-level checker for the quaternion pipeline, bound to the top level.
`default_nettype none
`include "rotation_matrix_to_quaternion_defines.svh"
module rmq_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input rmq_pkg::t_in   i_in_data,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input rmq_pkg::t_out  o_out_data
);
    import rmq_pkg::*;

    logic unused_in;
    assign unused_in = i_in_valid ^ (^i_in_data);

    `RMQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    `RMQ_ASSERT_NOW(a_in_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    `RMQ_ASSERT_NOW(a_degen_zero, i_clk, i_rst_n, o_out_valid && o_out_data.degenerate, o_out_data.qw == '0 && o_out_data.qx == '0 && o_out_data.qy == '0 && o_out_data.qz == '0)
    `RMQ_ASSERT_NOW(a_unit_range, i_clk, i_rst_n, o_out_valid, o_out_data.qw <= ONE && o_out_data.qw >= -ONE && o_out_data.qz <= ONE && o_out_data.qz >= -ONE)

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire

[tb/rmq_checker.sv]
// Checker for the rotation matrix to quaternion block: predicts and compares output beats.
`timescale 1ns / 1ps
module rmq_tb_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  rmq_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  rmq_pkg::t_out i_out_data,
    output int            o_errors,
    output int            o_pending,
    output int            o_results,
    output int            o_degenerate
);
    import rmq_pkg::*;

    t_out quat_q[$];

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_out matrix_to_quat(t_in m);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22, rad, one;
        longint v[4];
        longint unsigned mag[4];
        bit neg[4];
        longint unsigned mx, n2, norm, q;
        t_out res;
        one = longint'(1) << FRAC;
        a00 = m.r00; a01 = m.r01; a02 = m.r02;
        a10 = m.r10; a11 = m.r11; a12 = m.r12;
        a20 = m.r20; a21 = m.r21; a22 = m.r22;
        if (a00 + a11 + a22 > 0) begin
            v[0] = one + a00 + a11 + a22;
            v[1] = a21 - a12; v[2] = a02 - a20; v[3] = a10 - a01;
        end else if (a00 > a11 && a00 > a22) begin
            rad = one + a00 - a11 - a22;
            v[0] = a21 - a12; v[1] = rad < 0 ? 0 : rad;
            v[2] = a01 + a10; v[3] = a02 + a20;
        end else if (a11 > a22) begin
            rad = one + a11 - a00 - a22;
            v[0] = a02 - a20; v[1] = a01 + a10;
            v[2] = rad < 0 ? 0 : rad; v[3] = a12 + a21;
        end else begin
            rad = one + a22 - a00 - a11;
            v[0] = a10 - a01; v[1] = a02 + a20;
            v[2] = a12 + a21; v[3] = rad < 0 ? 0 : rad;
        end
        mx = 0;
        for (int i = 0; i < 4; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > mx) mx = mag[i];
        end
        res = '0;
        if (mx == 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        while (mx >= (64'd1 << 31)) begin
            mx >>= 1;
            for (int i = 0; i < 4; i++) mag[i] >>= 1;
        end
        while (mx < (64'd1 << 30)) begin
            mx <<= 1;
            for (int i = 0; i < 4; i++) mag[i] <<= 1;
        end
        n2 = 0;
        for (int i = 0; i < 4; i++) n2 += mag[i] * mag[i];
        norm = int_sqrt(n2);
        for (int i = 0; i < 4; i++) begin
            q = (mag[i] * longint'(one) + (norm >> 1)) / norm;
            if (neg[i]) q = -q;
            case (i)
                0: res.qw = q[DATA_WIDTH-1:0];
                1: res.qx = q[DATA_WIDTH-1:0];
                2: res.qy = q[DATA_WIDTH-1:0];
                default: res.qz = q[DATA_WIDTH-1:0];
            endcase
        end
        return res;
    endfunction

    assign o_pending = quat_q.size();

    always @(posedge i_clk) begin
        t_out exp_q;
        if (!i_rst_n) begin
            o_errors = 0;
            o_results = 0;
            o_degenerate = 0;
        end else begin
            if (i_in_valid && !i_in_stall) quat_q.push_back(matrix_to_quat(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (quat_q.size() == 0) begin
                    $error("output beat with no expected quaternion");
                    o_errors++;
                end else begin
                    exp_q = quat_q.pop_front();
                    o_results++;
                    if (exp_q.degenerate) o_degenerate++;
                    if (i_out_data.qw !== exp_q.qw) begin
                        $error("qw: expected %0d, got %0d", exp_q.qw, i_out_data.qw);
                        o_errors++;
                    end
                    if (i_out_data.qx !== exp_q.qx) begin
                        $error("qx: expected %0d, got %0d", exp_q.qx, i_out_data.qx);
                        o_errors++;
                    end
                    if (i_out_data.qy !== exp_q.qy) begin
                        $error("qy: expected %0d, got %0d", exp_q.qy, i_out_data.qy);
                        o_errors++;
                    end
                    if (i_out_data.qz !== exp_q.qz) begin
                        $error("qz: expected %0d, got %0d", exp_q.qz, i_out_data.qz);
                        o_errors++;
                    end
                    if (i_out_data.degenerate !== exp_q.degenerate) begin
                        $error("degenerate: expected %0b, got %0b",
                               exp_q.degenerate, i_out_data.degenerate);
                        o_errors++;
                    end
                end
            end
        end
    end
endmodule

[tb/testbench.sv]
// Top of the rotation matrix to quaternion testbench: stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import rmq_pkg::*;

    localparam int LATENCY = 53;
    localparam int N_RANDOM = 1230;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_data;
    int   errors, pending, results, degen_cnt;
    bit   hold_out = 1'b0;
    bit   no_idle = 1'b0;

    always #4 i_clk = ~i_clk;

    rotation_matrix_to_quaternion dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    rmq_tb_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_data(o_out_data),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_degenerate(degen_cnt)
    );

    // output back-pressure: random, none in the quiet stretch, solid while held
    always @(posedge i_clk) begin
        if (hold_out) i_out_stall <= 1'b1;
        else if (no_idle) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(99) < 9);
    end

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return $urandom_range(1) ? 16'sh4000 : -16'sh4000;
            3: return 16'(int'($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in rotation(int k);
        // near-rotations: random angle about a random axis, plus small noise
        real ang, x, y, z, n, c, s, t;
        real r[9];
        t_in m;
        ang = ($urandom_range(62831) / 10000.0);
        x = $urandom_range(2000) - 1000.0;
        y = $urandom_range(2000) - 1000.0;
        z = $urandom_range(2000) - 1000.0;
        n = $sqrt(x*x + y*y + z*z);
        if (n == 0.0) begin x = 1.0; n = 1.0; end
        x /= n; y /= n; z /= n;
        c = $cos(ang); s = $sin(ang); t = 1.0 - c;
        r[0] = t*x*x + c;   r[1] = t*x*y - s*z; r[2] = t*x*z + s*y;
        r[3] = t*x*y + s*z; r[4] = t*y*y + c;   r[5] = t*y*z - s*x;
        r[6] = t*x*z - s*y; r[7] = t*y*z + s*x; r[8] = t*z*z + c;
        m.r00 = 16'($rtoi(r[0]*16384.0) + k); m.r01 = 16'($rtoi(r[1]*16384.0));
        m.r02 = 16'($rtoi(r[2]*16384.0));     m.r10 = 16'($rtoi(r[3]*16384.0));
        m.r11 = 16'($rtoi(r[4]*16384.0) + k); m.r12 = 16'($rtoi(r[5]*16384.0));
        m.r20 = 16'($rtoi(r[6]*16384.0));     m.r21 = 16'($rtoi(r[7]*16384.0));
        m.r22 = 16'($rtoi(r[8]*16384.0) + k);
        return m;
    endfunction

    task automatic send_beat(t_in m);
        i_in_valid <= 1'b1;
        i_in_data <= m;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic maybe_idle();
        if (!no_idle) begin
            while ($urandom_range(99) < 9) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    function automatic t_in diag(logic signed [15:0] a, b, c);
        t_in m;
        m = '0;
        m.r00 = a; m.r11 = b; m.r22 = c;
        return m;
    endfunction

    initial begin
        t_in directed[$];
        t_in m;
        directed.push_back(diag(16'sh4000, 16'sh4000, 16'sh4000));   // identity
        directed.push_back(diag(16'sh4000, -16'sh4000, -16'sh4000)); // x half-turn
        directed.push_back(diag(-16'sh4000, 16'sh4000, -16'sh4000)); // y half-turn
        directed.push_back(diag(-16'sh4000, -16'sh4000, 16'sh4000)); // z half-turn
        directed.push_back(diag(16'sh0000, 16'sh0000, 16'sh0000));   // tie, all equal
        directed.push_back(diag(-16'sh2000, -16'sh2000, -16'sh2000));// tie, all equal, negative
        directed.push_back(diag(16'sh8000, 16'sh8000, 16'sh8000));   // all most negative
        directed.push_back(diag(16'sh7fff, 16'sh7fff, 16'sh7fff));
        directed.push_back(diag(16'sh8000, 16'sh8000, 16'sh4000));
        directed.push_back(diag(16'sh2000, 16'sh2000, -16'sh4000));  // tie x/y
        directed.push_back('1);
        m = '0; directed.push_back(m);
        m = {9{16'sh7fff}}; directed.push_back(m);
        m = {9{16'sh8000}}; directed.push_back(m);
        m = {16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
             16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
        directed.push_back(m);
        m = {16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
             16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
        directed.push_back(m);
        m = diag(16'sh8000, 16'sh8000, 16'sh8000);
        m.r01 = 16'sh1234; m.r10 = -16'sh1234; directed.push_back(m); // two nonzero components
        directed.push_back(rotation(0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            send_beat(directed[i]);
            maybe_idle();
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300) no_idle = 1'b1;
            if (n == 450) no_idle = 1'b0;
            if (n == 600) hold_out = 1'b1;
            if (n == 800) begin
                // pause until drained
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            case ($urandom_range(9))
                0, 1: begin
                    for (int k = 0; k < 9; k++) m[k*16 +: 16] = rand_elem();
                end
                2: begin
                    for (int k = 0; k < 9; k++) m[k*16 +: 16] = 16'($urandom);
                end
                default: m = rotation(int'($urandom_range(8)) - 4);
            endcase
            send_beat(m);
            maybe_idle();
        end
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("Covered %0d quaternions (%0d degenerate): identity, half-turns, ties,",
                 results, degen_cnt);
        $display("extreme elements, random rotations and noise under back-pressure.");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // long receiver hold-off, counted in its own process
    initial begin
        wait (hold_out);
        repeat (200) @(posedge i_clk);
        hold_out = 1'b0;
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
